FILE: rtl/ycr2rgb_pkg.sv
// Shared types, register codes and colour conversion constants for the YCbCr 4:2:0 converter.
`default_nettype none

package ycr2rgb_pkg;

   // Default largest line length in pixels; the chroma line store holds half of it.
   localparam int MAX_WIDTH_DEFAULT = 2048;

   // Largest number of rows a frame may have; taller settings are clamped to it.
   localparam int HEIGHT_LIMIT = 4096;

   localparam int FRAME_WIDTH_W  = 12;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int ROW_W          = 12;
   localparam int CHROMA_W       = 16;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One input beat: a luma sample and a chroma pair that is only used at even
   // columns of even rows.
   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic       frame_end;
   } rsp_type;

   // BT.601 limited range offsets.
   localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
   localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

   // Red and green use a 2^20 scale, blue a 2^19 scale.
   localparam logic signed [31:0] K_Y_RG  = 32'sd1220542;
   localparam logic signed [31:0] K_CR_R  = 32'sd1673527;
   localparam logic signed [31:0] K_CR_G  = 32'sd852492;
   localparam logic signed [31:0] K_CB_G  = 32'sd409993;
   localparam logic signed [31:0] K_Y_B   = 32'sd610271;
   localparam logic signed [31:0] K_CB_B  = 32'sd1058013;

   localparam int SHIFT_RG = 20;
   localparam int SHIFT_B  = 19;

   localparam logic signed [31:0] ROUND_RG = 32'sd524288;
   localparam logic signed [31:0] ROUND_B  = 32'sd262144;

   // Arithmetic shift (floor) followed by saturation to 0..255.
   function automatic logic [7:0] scale_clamp(input logic signed [31:0] sum, input int shift);
      logic signed [31:0] scaled;
      scaled = sum >>> shift;
      if (scaled < 0) begin
         scale_clamp = 8'd0;
      end else if (scaled > 32'sd255) begin
         scale_clamp = 8'd255;
      end else begin
         scale_clamp = scaled[7:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ycr2rgb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module ycr2rgb_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data only changes when a read is issued, so it holds across stalls.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ycbcr420_to_rgb_converter_top.sv
// Top level of the YCbCr 4:2:0 to RGB converter with chroma line store and frame framing.
// Each result beat passes through the input register, the product register and the result
// register before it reaches the port.
// Throughput: one pixel per cycle while rsp_stall is low, since every stage can then move on.
// Reset is synchronous and active high: counters, held chroma and pipeline valids are cleared
// and the frame size registers go to 640 by 480; the chroma line store is not cleared, and
// needs no clearing pass since every entry is written on an even row before an odd row reads it.
`default_nettype none

module ycbcr420_to_rgb_converter_top #(
   parameter int MAX_WIDTH = ycr2rgb_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Input channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire ycr2rgb_pkg::req_type                  req_data,
   // Result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output ycr2rgb_pkg::rsp_type                       rsp_data,
   // Configuration port
   input  wire logic                                  csr_we,
   input  wire ycr2rgb_pkg::csr_index_type            csr_index,
   input  wire logic [ycr2rgb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import ycr2rgb_pkg::*;

   // The store keeps one chroma pair for every two columns.
   localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   // Wide enough for a column count plus one, the largest width and the width register.
   localparam int CMP_W       = ($clog2(MAX_WIDTH + 1) > FRAME_WIDTH_W) ?
                                $clog2(MAX_WIDTH + 1) : FRAME_WIDTH_W;

   // ------------------------------------------------------------------
   // Configuration registers. Users must write only while the block is idle; it is not enforced.
   // ------------------------------------------------------------------
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_HEIGHT_W-1:0];
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. Each stage moves on when the stage after it is
   // empty or moving, so bubbles collapse and a waiting result beat does not
   // stop the input side from filling the earlier stages.
   // ------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic out_en, b_en, a_en, accept;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign b_en      = !b_valid_ff || out_en;
   assign a_en      = !a_valid_ff || b_en;
   assign req_stall = !a_en;
   assign accept    = req_valid && a_en;

   // ------------------------------------------------------------------
   // Raster position. The counters move on with every accepted beat, and the
   // end-of-row and end-of-frame flags are worked out for the beat itself.
   // ------------------------------------------------------------------
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [CMP_W-1:0]          col_plus;
   logic [FRAME_HEIGHT_W-1:0] row_plus;
   logic                      last_col, last_row;

   always_comb begin
      col_plus = CMP_W'(col_ff) + CMP_W'(1);
      row_plus = FRAME_HEIGHT_W'(row_ff) + FRAME_HEIGHT_W'(1);

      // A zero width behaves as one pixel, and widths beyond the store are clamped.
      last_col = (frame_width_ff == '0) ||
                 (col_plus >= CMP_W'(frame_width_ff)) ||
                 (col_plus >= CMP_W'(MAX_WIDTH));
      last_row = (frame_height_ff == '0) ||
                 (row_plus >= frame_height_ff) ||
                 (row_plus >= FRAME_HEIGHT_W'(HEIGHT_LIMIT));

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_plus[ROW_W-1:0];
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Chroma line store. An even row writes the new pair at each even column;
   // the odd row below reads it back at the same column pair.
   // ------------------------------------------------------------------
   logic                no_skip;
   logic                take_new, take_store;
   logic [STORE_AW-1:0] slot;
   logic [CHROMA_W-1:0] new_pair;
   logic [CHROMA_W-1:0] store_rd_data;

   assign no_skip    = !col_ff[0];
   assign take_new   = accept && no_skip && !row_ff[0];
   assign take_store = accept && no_skip && row_ff[0];
   assign slot       = STORE_AW'(col_ff >> 1);
   assign new_pair   = {req_data.chroma_blue, req_data.chroma_red};

   ycr2rgb_ram #(
      .WIDTH  (CHROMA_W),
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (STORE_AW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (take_new),
      .wr_addr (slot),
      .wr_data (new_pair),
      .rd_en   (take_store),
      .rd_addr (slot),
      .rd_data (store_rd_data)
   );

   // ------------------------------------------------------------------
   // Stage A: the accepted beat, its framing flags and which chroma source
   // it uses. The store read data lines up with this stage.
   // ------------------------------------------------------------------
   logic [7:0]          a_luma_ff;
   logic [CHROMA_W-1:0] a_pair_ff;
   logic                a_new_ff, a_store_ff, a_row_end_ff, a_frame_end_ff;
   logic [CHROMA_W-1:0] held_ff, held_in;
   logic                a_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_luma_ff      <= req_data.luma;
         a_pair_ff      <= new_pair;
         a_new_ff       <= no_skip && !row_ff[0];
         a_store_ff     <= no_skip && row_ff[0];
         a_row_end_ff   <= last_col;
         a_frame_end_ff <= last_col && last_row;
      end
   end

   assign a_move = a_valid_ff && b_en;

   // The held pair serves the odd column after each even one.
   always_comb begin
      held_in = held_ff;
      if (a_new_ff) begin
         held_in = a_pair_ff;
      end else if (a_store_ff) begin
         held_in = store_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (a_move) begin
         held_ff <= held_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: offset removal and the six coefficient products.
   // ------------------------------------------------------------------
   logic signed [8:0]  y_diff, cb_diff, cr_diff;
   logic signed [31:0] b_y_rg_ff, b_cr_r_ff, b_cr_g_ff, b_cb_g_ff, b_y_b_ff, b_cb_b_ff;
   logic               b_row_end_ff, b_frame_end_ff;

   always_comb begin
      y_diff  = $signed({1'b0, a_luma_ff}) - LUMA_OFFSET;
      cb_diff = $signed({1'b0, held_in[15:8]}) - CHROMA_OFFSET;
      cr_diff = $signed({1'b0, held_in[7:0]}) - CHROMA_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_y_rg_ff      <= K_Y_RG * y_diff;
         b_cr_r_ff      <= K_CR_R * cr_diff;
         b_cr_g_ff      <= K_CR_G * cr_diff;
         b_cb_g_ff      <= K_CB_G * cb_diff;
         b_y_b_ff       <= K_Y_B * y_diff;
         b_cb_b_ff      <= K_CB_B * cb_diff;
         b_row_end_ff   <= a_row_end_ff;
         b_frame_end_ff <= a_frame_end_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output stage: rounding sums, scaling and saturation into the result
   // register that faces the result channel.
   // ------------------------------------------------------------------
   logic signed [31:0] sum_r, sum_g, sum_b;
   rsp_type            rsp_data_ff, rsp_data_in;

   always_comb begin
      sum_r = b_y_rg_ff + b_cr_r_ff + ROUND_RG;
      sum_g = b_y_rg_ff - b_cr_g_ff - b_cb_g_ff + ROUND_RG;
      sum_b = b_y_b_ff + b_cb_b_ff + ROUND_B;

      rsp_data_in.red       = scale_clamp(sum_r, SHIFT_RG);
      rsp_data_in.green     = scale_clamp(sum_g, SHIFT_RG);
      rsp_data_in.blue      = scale_clamp(sum_b, SHIFT_B);
      rsp_data_in.row_end   = b_row_end_ff;
      rsp_data_in.frame_end = b_frame_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && b_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: tb/sv/rgb_pixel_check_pkg.sv
// Pixel scoreboard for the YCbCr 4:2:0 converter: chroma upsampling, BT.601 conversion and framing.
package rgb_pixel_check_pkg;

   import ycr2rgb_pkg::*;

   localparam int LINE_PIXELS  = MAX_WIDTH_DEFAULT;
   localparam int CHROMA_SLOTS = LINE_PIXELS / 2;
   localparam int ROW_CEILING  = 4096;

   // BT.601 limited range gains: red and green on a 2^20 scale, blue on 2^19.
   localparam longint RG_LUMA_GAIN  = 1220542;
   localparam longint R_CR_GAIN     = 1673527;
   localparam longint G_CR_GAIN     = 852492;
   localparam longint G_CB_GAIN     = 409993;
   localparam longint B_LUMA_GAIN   = 610271;
   localparam longint B_CB_GAIN     = 1058013;
   localparam longint RG_HALF       = 524288;
   localparam longint B_HALF        = 262144;

   class rgb_pixel_scoreboard;

      logic [FRAME_WIDTH_W-1:0]  width_setting;
      logic [FRAME_HEIGHT_W-1:0] height_setting;
      logic [CHROMA_W-1:0]       chroma_line [CHROMA_SLOTS];
      logic [10:0]               column;
      logic [ROW_W-1:0]          row;
      logic [CHROMA_W-1:0]       held_pair;
      rsp_type                   expected_pixels [$];
      int unsigned               mismatch_count;

      function new();
         width_setting  = 12'd640;
         height_setting = 13'd480;
         column         = '0;
         row            = '0;
         held_pair      = '0;
         mismatch_count = 0;
      endfunction

      function void set_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_FRAME_WIDTH: begin
               width_setting = value[FRAME_WIDTH_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               height_setting = value;
            end
            default: begin
            end
         endcase
      endfunction

      function int effective_width();
         int w;
         w = width_setting;
         if (w < 1) w = 1;
         if (w > LINE_PIXELS) w = LINE_PIXELS;
         return w;
      endfunction

      function int effective_height();
         int h;
         h = height_setting;
         if (h < 1) h = 1;
         if (h > ROW_CEILING) h = ROW_CEILING;
         return h;
      endfunction

      function int frame_pixels();
         return effective_width() * effective_height();
      endfunction

      function bit at_frame_start();
         return column == '0 && row == '0;
      endfunction

      function bit row_is_odd();
         return row[0];
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function logic [7:0] saturate(longint v);
         if (v < 0) return 8'd0;
         if (v > 255) return 8'd255;
         return v[7:0];
      endfunction

      // Fixed-point colour conversion; the shifts are arithmetic, so they round towards minus
      // infinity after the half has been added.
      function rsp_type convert_to_rgb(logic [7:0] luma, logic [CHROMA_W-1:0] pair);
         longint yd;
         longint bd;
         longint rd;
         rsp_type px;
         yd = longint'(luma) - 16;
         bd = longint'(pair[15:8]) - 128;
         rd = longint'(pair[7:0]) - 128;
         px.red       = saturate((RG_LUMA_GAIN * yd + R_CR_GAIN * rd + RG_HALF) >>> 20);
         px.green     = saturate((RG_LUMA_GAIN * yd - G_CR_GAIN * rd - G_CB_GAIN * bd
                                  + RG_HALF) >>> 20);
         px.blue      = saturate((B_LUMA_GAIN * yd + B_CB_GAIN * bd + B_HALF) >>> 19);
         px.row_end   = 1'b0;
         px.frame_end = 1'b0;
         return px;
      endfunction

      function void note_input_pixel(req_type pixel);
         int slot;
         bit last_col;
         bit last_row;
         rsp_type want;
         slot = column >> 1;
         if (!column[0]) begin
            if (!row[0]) begin
               held_pair         = {pixel.chroma_blue, pixel.chroma_red};
               chroma_line[slot] = held_pair;
            end else begin
               held_pair = chroma_line[slot];
            end
         end
         want = convert_to_rgb(pixel.luma, held_pair);
         // Counters left past the limits by a write end the row at once, the frame at the row end.
         last_col       = int'(column) + 1 >= effective_width();
         last_row       = int'(row) + 1 >= effective_height();
         want.row_end   = last_col;
         want.frame_end = last_col && last_row;
         if (last_col) begin
            column = '0;
            row    = last_row ? '0 : row + 1'b1;
         end else begin
            column = column + 1'b1;
         end
         expected_pixels.push_back(want);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_output_pixel(rsp_type got);
         rsp_type want;
         if (expected_pixels.size() == 0) begin
            $error("result beat %h arrived with no pixel outstanding", got);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("row_end", 8'(want.row_end), 8'(got.row_end));
            compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
         end
      endfunction

   endclass

endpackage

FILE: tb/sv/ycbcr420_to_rgb_converter_top_tb.sv
// Self-checking bench for the YCbCr 4:2:0 to RGB converter top level.
module ycbcr420_to_rgb_converter_top_tb;

   import ycr2rgb_pkg::*;
   import rgb_pixel_check_pkg::*;

   // The pipeline is three stages deep, so a few spare cycles cover anything still in flight.
   localparam int DRAIN_SLACK     = 6;
   localparam int HOLD_OFF_CYCLES = 200;
   // Longest legal quiet spell is the deliberate hold-off plus a run of random stalls.
   localparam int WATCHDOG_LIMIT  = 2000;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we    = 1'b0;
   csr_index_type           csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Percentages of cycles in which each side holds back; changed between phases.
   int unsigned             sender_idle_pct   = 0;
   int unsigned             receiver_idle_pct = 0;
   logic                    pressure_request  = 1'b0;
   logic                    hold_off_done     = 1'b0;
   int                      hold_off_left     = 0;
   int unsigned             pixels_sent       = 0;

   rgb_pixel_scoreboard     board;

   ycbcr420_to_rgb_converter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Receiver side. Normally it stalls at random; once the pressure phase is asked for it
   // holds off for a long stretch of its own, so that the block backs up and stalls its input.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (pressure_request && !hold_off_done) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= HOLD_OFF_CYCLES;
         hold_off_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Every accepted result beat is held against the oldest outstanding pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_output_pixel(rsp_data);
      end
   end

   // Watchdog: the run is abandoned if nothing moves on any port for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   function automatic req_type make_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
      req_type p;
      p.luma        = luma;
      p.chroma_blue = cb;
      p.chroma_red  = cr;
      return p;
   endfunction

   // Uniform samples, with each field pinned to one end of its range now and then so that
   // saturation at both ends turns up often.
   function automatic req_type random_pixel();
      req_type p;
      p.luma        = 8'($urandom);
      p.chroma_blue = 8'($urandom);
      p.chroma_red  = 8'($urandom);
      if ($urandom_range(7) == 0) p.luma = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(7) == 0) p.chroma_blue = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(7) == 0) p.chroma_red = $urandom_range(1) ? 8'hFF : 8'h00;
      return p;
   endfunction

   // Offers one beat, perhaps after a few idle cycles, and returns at the edge that takes it.
   // Valid is left high so that back-to-back beats need no extra cycle.
   task automatic send_pixel(input req_type pixel);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_input_pixel(pixel);
      pixels_sent++;
   endtask

   // Stops offering and waits until every outstanding pixel has come back, plus a margin.
   task automatic wait_for_pipeline_empty();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Single register write; the trailing cycle keeps back-to-back writes apart.
   task automatic write_register(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.set_register(index, value);
      @(posedge clock);
   endtask

   // Random frames until the running pixel count reaches the target. Most frames are small;
   // some are wide and short, some odd or zero in width, some zero in height. Now and then
   // the frame size is changed part way through a frame.
   task automatic run_random_frames(input int unsigned target);
      logic [FRAME_WIDTH_W-1:0]  w;
      logic [FRAME_HEIGHT_W-1:0] h;
      int unsigned               first_part;
      while (pixels_sent < target) begin
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(9))
               0: begin
                  w = 12'($urandom_range(21, 64) * 2);
                  h = 13'($urandom_range(1, 2));
               end
               1: begin
                  w = 12'($urandom_range(0, 8) * 2 + 1);
                  h = 13'($urandom_range(1, 5));
               end
               2: begin
                  w = 12'($urandom_range(0, 1) * 2);
                  h = 13'($urandom_range(0, 3));
               end
               default: begin
                  w = 12'($urandom_range(1, 8) * 2);
                  h = 13'($urandom_range(1, 6));
               end
            endcase
            wait_for_pipeline_empty();
            write_register(CSR_FRAME_WIDTH, w);
            write_register(CSR_FRAME_HEIGHT, h);
         end
         first_part = $urandom_range(1, board.frame_pixels());
         repeat (first_part) send_pixel(random_pixel());
         if (!board.at_frame_start() && $urandom_range(3) == 0) begin
            wait_for_pipeline_empty();
            if ($urandom_range(1) == 0) begin
               // On an odd row the line store only holds chroma up to the present width, so
               // the width may only shrink there; on an even row the store is being refilled.
               if (board.row_is_odd()) begin
                  w = 12'($urandom_range(1, board.effective_width()));
               end else begin
                  w = 12'($urandom_range(0, 32));
               end
               write_register(CSR_FRAME_WIDTH, w);
            end else begin
               write_register(CSR_FRAME_HEIGHT, 13'($urandom_range(0, 8)));
            end
         end
         while (!board.at_frame_start()) send_pixel(random_pixel());
      end
   endtask

   initial begin
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed part runs with the sender idling a quarter of the time and the
      // receiver nearly half.
      sender_idle_pct   = 25;
      receiver_idle_pct = 47;

      // A 4 by 2 frame: black and white levels, chroma at both ends of its range, and chroma
      // offered at odd columns, where it must be ignored. The odd row reuses the stored pairs.
      write_register(CSR_FRAME_WIDTH, 4);
      write_register(CSR_FRAME_HEIGHT, 2);
      send_pixel(make_pixel(8'd16, 8'd128, 8'd128));
      send_pixel(make_pixel(8'd235, 8'd0, 8'd0));
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0));
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255));
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255));
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0));
      send_pixel(make_pixel(8'd255, 8'd0, 8'd0));
      send_pixel(make_pixel(8'd0, 8'd255, 8'd255));

      // Width and height of zero are taken as one: every beat ends a row and a frame.
      wait_for_pipeline_empty();
      write_register(CSR_FRAME_WIDTH, 0);
      write_register(CSR_FRAME_HEIGHT, 0);
      send_pixel(make_pixel(8'd255, 8'd255, 8'd0));
      send_pixel(make_pixel(8'd0, 8'd0, 8'd255));

      // Odd width: the last column is even and picks up a fresh chroma pair.
      wait_for_pipeline_empty();
      write_register(CSR_FRAME_WIDTH, 3);
      write_register(CSR_FRAME_HEIGHT, 2);
      send_pixel(make_pixel(8'd128, 8'd255, 8'd255));
      send_pixel(make_pixel(8'd128, 8'd0, 8'd0));
      send_pixel(make_pixel(8'd200, 8'd0, 8'd255));
      send_pixel(make_pixel(8'd50, 8'd17, 8'd99));
      send_pixel(make_pixel(8'd60, 8'd200, 8'd3));
      send_pixel(make_pixel(8'd70, 8'd255, 8'd0));

      // Register values above the limits are clamped. Part way into the first row the width
      // is cut below the column count, which must end the row at once; later the height is
      // cut below the row count, which must end the frame at the next row end.
      wait_for_pipeline_empty();
      write_register(CSR_FRAME_WIDTH, 4095);
      write_register(CSR_FRAME_HEIGHT, 8191);
      send_pixel(make_pixel(8'd255, 8'd0, 8'd255));
      send_pixel(make_pixel(8'd0, 8'd255, 8'd0));
      send_pixel(make_pixel(8'd255, 8'd255, 8'd0));
      send_pixel(make_pixel(8'd0, 8'd0, 8'd255));
      wait_for_pipeline_empty();
      write_register(CSR_FRAME_WIDTH, 2);
      send_pixel(make_pixel(8'd128, 8'd128, 8'd128));
      send_pixel(make_pixel(8'd16, 8'd77, 8'd211));
      send_pixel(make_pixel(8'd235, 8'd5, 8'd5));
      send_pixel(make_pixel(8'd90, 8'd240, 8'd16));
      wait_for_pipeline_empty();
      write_register(CSR_FRAME_HEIGHT, 2);
      send_pixel(make_pixel(8'd180, 8'd1, 8'd254));

      // Random frames, first with the idling as above, then the other way round.
      run_random_frames(650);
      sender_idle_pct   = 47;
      receiver_idle_pct = 25;
      run_random_frames(1300);

      // No idling from here on. First a whole frame sent flat out while the receiver holds
      // off for a long stretch, so that the pipeline fills and the input is stalled.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      wait_for_pipeline_empty();
      write_register(CSR_FRAME_WIDTH, 16);
      write_register(CSR_FRAME_HEIGHT, 8);
      pressure_request <= 1'b1;
      repeat (128) send_pixel(random_pixel());
      run_random_frames(1900);

      wait_for_pipeline_empty();
      if (board.mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
